[hw/rtl/tick_delay_wakeup_queue_assert.svh]
// Assertion macros used by the tick delay wakeup queue checker.
`ifndef TICK_DELAY_WAKEUP_QUEUE_ASSERT_SVH
`define TICK_DELAY_WAKEUP_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDWQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tdwq_pkg.sv]
// Shared codes, queue entry type and controller/datapath interface structs.
package tdwq_pkg;

  localparam int TIME_W = 32;
  localparam int TASK_W = 6;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_REL   = 2'd2;
  localparam logic [1:0] KIND_ABS   = 2'd3;

  localparam logic [1:0] REPLY_TICK_ACK = 2'd0;
  localparam logic [1:0] REPLY_TIME     = 2'd1;
  localparam logic [1:0] REPLY_WOKEN    = 2'd2;
  localparam logic [1:0] REPLY_REJECT   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [TASK_W-1:0] task_id;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic send;
    logic release_head;
  } tdwq_cmd_t;

  typedef struct packed {
    logic insert_new;
    logic ins_at_head;
    logic ins_greater;
    logic head_due;
    logic pend_valid;
    logic out_free;
  } tdwq_sts_t;

endpackage

[hw/rtl/tick_delay_wakeup_queue.sv]
// Top level of the tick delay wakeup queue.
// The block counts ticks and keeps up to QUEUE_DEPTH waiting tasks in a circular
// queue held in one RAM, sorted by wake time (unsigned, ties in arrival order).
// One item is handled at a time; in_ready is high only while the block is idle.
// A tick, a time query or a delay refused because the queue is full skips insertion.
// An accepted delay walks back from the tail through the RAM's single read port,
// reading and moving one later entry at a time, until it lands at the head of the
// queue or behind an entry whose wake time is not later.
// Each released task is then handled by a head read, then a compare and release.
// Every reply passes through an output register, so the next item is accepted
// while the final reply of the previous one still waits to be taken.
module tick_delay_wakeup_queue import tdwq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [TASK_W-1:0] in_task_id,
  input  logic [TIME_W-1:0] in_time_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_reply_kind,
  output logic [TASK_W-1:0] out_reply_task,
  output logic [TIME_W-1:0] out_reply_time,
  output logic              out_last_reply
);

  tdwq_cmd_t cmd;
  tdwq_sts_t sts;

  tdwq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tdwq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_task_id    (in_task_id),
    .in_time_value (in_time_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_reply_kind(out_reply_kind),
    .out_reply_task(out_reply_task),
    .out_reply_time(out_reply_time),
    .out_last_reply(out_last_reply)
  );

endmodule

[hw/rtl/tdwq_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module tdwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/tdwq_ctrl.sv]
// Sequencing state machine for insertion, release scan and reply hand-off.
module tdwq_ctrl import tdwq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tdwq_sts_t sts,
  output tdwq_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_HD_RD,
    ST_HD_EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.insert_new ? ST_INS_RD : ST_HD_RD;
        end
      end
      ST_INS_RD: begin
        if (sts.ins_at_head) begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_HD_RD;
        end else begin
          cmd.ins_read = 1'b1;
          state_nxt    = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.ins_greater) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = ST_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_HD_RD;
        end
      end
      ST_HD_RD: begin
        state_nxt = ST_HD_EVAL;
      end
      ST_HD_EVAL: begin
        if (!sts.pend_valid && !sts.head_due) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.send         = sts.pend_valid;
          cmd.release_head = sts.head_due;
          state_nxt        = sts.head_due ? ST_HD_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/tdwq_datapath.sv]
// Tick counter, circular sorted wake queue in RAM, pending reply and output register.
module tdwq_datapath import tdwq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_kind,
  input  logic [TASK_W-1:0] in_task_id,
  input  logic [TIME_W-1:0] in_time_value,
  input  tdwq_cmd_t         cmd,
  output tdwq_sts_t         sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_reply_kind,
  output logic [TASK_W-1:0] out_reply_task,
  output logic [TIME_W-1:0] out_reply_time,
  output logic              out_last_reply
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(QUEUE_DEPTH);

  logic [TIME_W-1:0] tick_r;
  logic [CW-1:0]     fill_r;
  logic [AW-1:0]     head_r;
  logic [TIME_W-1:0] when_r;
  logic [TASK_W-1:0] task_r;
  logic [CW-1:0]     ins_pos_r;
  logic              pend_valid_r;
  logic [1:0]        pend_kind_r;
  logic [TASK_W-1:0] pend_task_r;
  logic [TIME_W-1:0] pend_time_r;
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [TASK_W-1:0] out_task_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_last_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  logic              is_delay;

  // Maps a position counted from the queue head to a RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lpos);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW + 1)'(lpos);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  tdwq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign is_delay  = (in_kind == KIND_REL) || (in_kind == KIND_ABS);
  assign ram_we    = cmd.ins_shift | cmd.ins_place;
  assign ram_waddr = phys(head_r, ins_pos_r);
  assign ram_wdata = cmd.ins_shift ? ram_rdata : entry_t'{wake: when_r, task_id: task_r};
  assign ram_raddr = cmd.ins_read ? phys(head_r, ins_pos_r - CW'(1)) : head_r;

  assign sts.insert_new  = is_delay && (fill_r != DEPTH_C);
  assign sts.ins_at_head = (ins_pos_r == '0);
  assign sts.ins_greater = (ram_rdata.wake > when_r);
  assign sts.head_due    = (fill_r != '0) && (ram_rdata.wake <= tick_r);
  assign sts.pend_valid  = pend_valid_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      fill_r       <= '0;
      head_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept && (in_kind == KIND_TICK)) begin
        tick_r <= tick_r + TIME_W'(1);
      end
      if (cmd.accept) begin
        pend_valid_r <= !sts.insert_new;
      end else if (cmd.release_head) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.send) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.ins_place) begin
        fill_r <= fill_r + CW'(1);
      end else if (cmd.release_head) begin
        fill_r <= fill_r - CW'(1);
      end
      if (cmd.release_head) begin
        head_r <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      if (cmd.send) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      when_r      <= (in_kind == KIND_REL) ? tick_r + in_time_value : in_time_value;
      task_r      <= in_task_id;
      ins_pos_r   <= fill_r;
      pend_task_r <= in_task_id;
      pend_time_r <= (in_kind == KIND_QUERY) ? tick_r : '0;
      unique case (in_kind)
        KIND_TICK:  pend_kind_r <= REPLY_TICK_ACK;
        KIND_QUERY: pend_kind_r <= REPLY_TIME;
        default:    pend_kind_r <= REPLY_REJECT;
      endcase
    end else if (cmd.release_head) begin
      pend_kind_r <= REPLY_WOKEN;
      pend_task_r <= ram_rdata.task_id;
      pend_time_r <= '0;
    end
    if (cmd.ins_shift) begin
      ins_pos_r <= ins_pos_r - CW'(1);
    end
    if (cmd.send) begin
      out_kind_r <= pend_kind_r;
      out_task_r <= pend_task_r;
      out_time_r <= pend_time_r;
      out_last_r <= !sts.head_due;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_reply_task = out_task_r;
  assign out_reply_time = out_time_r;
  assign out_last_reply = out_last_r;

endmodule

[hw/rtl/tdwq_checker.sv]
// Port-level checker for the tick delay wakeup queue and its bind statement.
`include "tick_delay_wakeup_queue_assert.svh"

module tdwq_checker import tdwq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_kind,
  input logic [TASK_W-1:0] in_task_id,
  input logic [TIME_W-1:0] in_time_value,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_reply_kind,
  input logic [TASK_W-1:0] out_reply_task,
  input logic [TIME_W-1:0] out_reply_time,
  input logic              out_last_reply
);

  `TDWQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `TDWQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_reply_kind) && $stable(out_reply_task) && $stable(out_reply_time) && $stable(out_last_reply), "output item changed while stalled")
  `TDWQ_ASSERT_SAME(a_time_zero, out_valid && (out_reply_kind != REPLY_TIME), out_reply_time == '0, "nonzero time on non-time reply")
  `TDWQ_ASSERT_SAME(a_reject_last, out_valid && (out_reply_kind == REPLY_REJECT), out_last_reply, "rejected delay not the final reply")

endmodule

bind tick_delay_wakeup_queue tdwq_checker u_tdwq_checker (.*);
